@@ rtl/fpdq16_pkg.sv @@
// Shared constants for the signed Q16.16 fixed-point divider.
package fpdq16_pkg;

   localparam int DATA_W            = 32;
   localparam int FRAC_BITS_DEFAULT = 16;

   typedef logic [DATA_W-1:0] word_type;

   // two's complement magnitude as an unsigned word
   function automatic word_type magnitude(input word_type x);
      magnitude = x[DATA_W-1] ? (~x + word_type'(1)) : x;
   endfunction

endpackage

@@ rtl/fixed_point_divide_q16_top.sv @@
// Signed Q16.16 fixed-point divider with one restoring-division stage per quotient bit.
//
// One operand pair can enter on every clock: busy stays low and start alone
// launches an item. The result appears on the rsp_ ports, marked by rsp_valid
// for exactly one cycle. Each item passes one register for the operand
// magnitudes, then the chain of 32 + FRAC_BITS shift-and-subtract stages,
// one quotient bit per stage, then one register for the sign and the flags.
// The quotient is truncated toward zero and keeps its low 32 bits when its
// magnitude does not fit in 31 bits; rsp_overflow flags that case. A zero
// divisor gives a quotient of 0 with rsp_divide_by_zero set.
module fixed_point_divide_q16_top #(
   parameter int FRAC_BITS = fpdq16_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [fpdq16_pkg::DATA_W-1:0] req_dividend,
   input  logic signed [fpdq16_pkg::DATA_W-1:0] req_divisor,
   output logic                          rsp_valid,
   output logic signed [fpdq16_pkg::DATA_W-1:0] rsp_quotient,
   output logic                          rsp_overflow,
   output logic                          rsp_divide_by_zero
);

   localparam int DW  = fpdq16_pkg::DATA_W;
   localparam int NQ  = DW + FRAC_BITS;
   localparam int LAT = NQ + 2;

   // pipeline: index 0 is the operand stage, 1..NQ the division steps
   logic          vld_ff  [0:NQ];
   logic          neg_ff  [0:NQ];
   logic          dz_ff   [0:NQ];
   logic [DW-1:0] mb_ff   [0:NQ];
   logic [DW-1:0] rem_ff  [0:NQ];
   logic [NQ-1:0] work_ff [0:NQ];

   logic [DW-1:0] rem_in  [0:NQ];
   logic [NQ-1:0] work_in [0:NQ];

   logic          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0] rsp_quot_ff, rsp_quot_in;
   logic          rsp_ovf_ff, rsp_ovf_in;
   logic          rsp_dz_ff, rsp_dz_in;

   logic [DW-1:0] ma_mag;
   logic [DW-1:0] mb_mag;

   assign busy = 1'b0;

   // operand stage
   always_comb begin
      ma_mag     = fpdq16_pkg::magnitude(req_dividend);
      mb_mag     = fpdq16_pkg::magnitude(req_divisor);
      rem_in[0]  = '0;
      work_in[0] = {ma_mag, {FRAC_BITS{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= start & ~busy;
      end
      neg_ff[0]  <= req_dividend[DW-1] ^ req_divisor[DW-1];
      dz_ff[0]   <= (req_divisor == '0);
      mb_ff[0]   <= mb_mag;
      rem_ff[0]  <= rem_in[0];
      work_ff[0] <= work_in[0];
   end

   // division steps
   for (genvar i = 1; i <= NQ; i++) begin : g_step
      logic [DW:0] part;
      logic        ge;

      always_comb begin
         part       = {rem_ff[i-1], work_ff[i-1][NQ-1]};
         ge         = (part >= {1'b0, mb_ff[i-1]});
         rem_in[i]  = ge ? DW'(part - {1'b0, mb_ff[i-1]}) : part[DW-1:0];
         work_in[i] = {work_ff[i-1][NQ-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= vld_ff[i-1];
         end
         neg_ff[i]  <= neg_ff[i-1];
         dz_ff[i]   <= dz_ff[i-1];
         mb_ff[i]   <= mb_ff[i-1];
         rem_ff[i]  <= rem_in[i];
         work_ff[i] <= work_in[i];
      end
   end

   // sign, flags and output register
   always_comb begin
      rsp_valid_in = vld_ff[NQ];
      rsp_dz_in    = dz_ff[NQ];
      if (dz_ff[NQ]) begin
         rsp_quot_in = '0;
         rsp_ovf_in  = 1'b0;
      end else begin
         rsp_quot_in = neg_ff[NQ] ? (~work_ff[NQ][DW-1:0] + DW'(1)) : work_ff[NQ][DW-1:0];
         rsp_ovf_in  = |work_ff[NQ][NQ-1:DW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_quot_ff <= rsp_quot_in;
      rsp_ovf_ff  <= rsp_ovf_in;
      rsp_dz_ff   <= rsp_dz_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_quotient       = rsp_quot_ff;
   assign rsp_overflow       = rsp_ovf_ff;
   assign rsp_divide_by_zero = rsp_dz_ff;

   a_zero_divisor : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |-> rsp_quotient == '0 && !rsp_overflow)
      else $error("zero divisor result not cleared");

   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result without an item taken at the expected latency");

   a_sign : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_divide_by_zero && !rsp_overflow && rsp_quotient != '0
      |-> rsp_quotient[DW-1] == ($past(req_dividend[DW-1], LAT) ^ $past(req_divisor[DW-1], LAT)))
      else $error("quotient sign mismatch");

endmodule
